[sv/sunls_pkg.sv]
package sunls_pkg;

  localparam int WideW = 128;  // solve-side word, arithmetic wraps mod 2^WideW
  localparam int BW    = 40;   // multiplier operand B (signed), one bit per cycle
  localparam int OutW  = 20;   // Q3.16 vector component
  localparam int PcW   = 6;
  localparam int NormW = 16;
  localparam logic signed [NormW-1:0] NormMax = 16'sd16384;
  localparam logic signed [NormW-1:0] NormMin = -16'sd16384;
  localparam logic [OutW:0] CapPos = 21'd524287;
  localparam logic [OutW:0] CapNeg = 21'd524288;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_FEW   = 2'd1,
    ST_ILL   = 2'd2
  } status_code_t;

  typedef enum logic [3:0] {
    OP_MSET    = 4'd0,
    OP_MSUB    = 4'd1,
    OP_MADD    = 4'd2,
    OP_STADJ   = 4'd3,
    OP_STDET   = 4'd4,
    OP_CHKDET  = 4'd5,
    OP_NFIRST  = 4'd6,
    OP_NACC    = 4'd7,
    OP_NMAX    = 4'd8,
    OP_STPROD  = 4'd9,
    OP_CHKCOND = 4'd10,
    OP_DIV     = 4'd11,
    OP_END     = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    A_M      = 2'd0,
    A_ADJ    = 2'd1,
    A_BEST   = 2'd2,
    A_DETMAG = 2'd3
  } asel_t;

  typedef enum logic [1:0] {
    B_M     = 2'd0,
    B_S     = 2'd1,
    B_N1    = 2'd2,
    B_LIMIT = 2'd3
  } bsel_t;

  typedef struct packed {
    op_t        op;
    asel_t      asel;
    logic [3:0] aidx;
    bsel_t      bsel;
    logic [2:0] bidx;
  } uop_t;

  typedef struct packed {
    logic         load;
    logic         acc;
    logic [1:0]   acc_phase;
    logic         exec;
    uop_t         uop;
    logic         emit;
    status_code_t emit_status;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic last;
    logic enough;
    logic det_zero;
    logic cond_fail;
    logic out_free;
  } stat_t;

  function automatic uop_t mk(op_t o, asel_t a, logic [3:0] ai, bsel_t b, logic [2:0] bi);
    uop_t u;
    u.op   = o;
    u.asel = a;
    u.aidx = ai;
    u.bsel = b;
    u.bidx = bi;
    return u;
  endfunction

  // Solve program: adjugate, determinant, 1-norms, condition test, solve.
  function automatic uop_t ucode(logic [PcW-1:0] pc);
    uop_t u;
    u = mk(OP_END, A_M, 4'd0, B_M, 3'd0);
    case (pc)
      // adj[k] = p*q - r*s over the symmetric Gram sums
      6'd0:  u = mk(OP_MSET,  A_M, 4'd3, B_M, 3'd5);
      6'd1:  u = mk(OP_MSUB,  A_M, 4'd4, B_M, 3'd4);
      6'd2:  u = mk(OP_STADJ, A_M, 4'd0, B_M, 3'd0);
      6'd3:  u = mk(OP_MSET,  A_M, 4'd2, B_M, 3'd4);
      6'd4:  u = mk(OP_MSUB,  A_M, 4'd1, B_M, 3'd5);
      6'd5:  u = mk(OP_STADJ, A_M, 4'd1, B_M, 3'd0);
      6'd6:  u = mk(OP_MSET,  A_M, 4'd1, B_M, 3'd4);
      6'd7:  u = mk(OP_MSUB,  A_M, 4'd2, B_M, 3'd3);
      6'd8:  u = mk(OP_STADJ, A_M, 4'd2, B_M, 3'd0);
      6'd9:  u = mk(OP_MSET,  A_M, 4'd4, B_M, 3'd2);
      6'd10: u = mk(OP_MSUB,  A_M, 4'd1, B_M, 3'd5);
      6'd11: u = mk(OP_STADJ, A_M, 4'd3, B_M, 3'd0);
      6'd12: u = mk(OP_MSET,  A_M, 4'd0, B_M, 3'd5);
      6'd13: u = mk(OP_MSUB,  A_M, 4'd2, B_M, 3'd2);
      6'd14: u = mk(OP_STADJ, A_M, 4'd4, B_M, 3'd0);
      6'd15: u = mk(OP_MSET,  A_M, 4'd2, B_M, 3'd1);
      6'd16: u = mk(OP_MSUB,  A_M, 4'd0, B_M, 3'd4);
      6'd17: u = mk(OP_STADJ, A_M, 4'd5, B_M, 3'd0);
      6'd18: u = mk(OP_MSET,  A_M, 4'd1, B_M, 3'd4);
      6'd19: u = mk(OP_MSUB,  A_M, 4'd3, B_M, 3'd2);
      6'd20: u = mk(OP_STADJ, A_M, 4'd6, B_M, 3'd0);
      6'd21: u = mk(OP_MSET,  A_M, 4'd1, B_M, 3'd2);
      6'd22: u = mk(OP_MSUB,  A_M, 4'd0, B_M, 3'd4);
      6'd23: u = mk(OP_STADJ, A_M, 4'd7, B_M, 3'd0);
      6'd24: u = mk(OP_MSET,  A_M, 4'd0, B_M, 3'd3);
      6'd25: u = mk(OP_MSUB,  A_M, 4'd1, B_M, 3'd1);
      6'd26: u = mk(OP_STADJ, A_M, 4'd8, B_M, 3'd0);
      // determinant along the first column
      6'd27: u = mk(OP_MSET,   A_ADJ, 4'd0, B_M, 3'd0);
      6'd28: u = mk(OP_MADD,   A_ADJ, 4'd3, B_M, 3'd1);
      6'd29: u = mk(OP_MADD,   A_ADJ, 4'd6, B_M, 3'd2);
      6'd30: u = mk(OP_STDET,  A_M,   4'd0, B_M, 3'd0);
      6'd31: u = mk(OP_CHKDET, A_M,   4'd0, B_M, 3'd0);
      // column sums of |adj| and |M|
      6'd32: u = mk(OP_NFIRST, A_ADJ, 4'd0, B_M, 3'd0);
      6'd33: u = mk(OP_NACC,   A_ADJ, 4'd3, B_M, 3'd1);
      6'd34: u = mk(OP_NACC,   A_ADJ, 4'd6, B_M, 3'd2);
      6'd35: u = mk(OP_NMAX,   A_M,   4'd0, B_M, 3'd0);
      6'd36: u = mk(OP_NFIRST, A_ADJ, 4'd1, B_M, 3'd1);
      6'd37: u = mk(OP_NACC,   A_ADJ, 4'd4, B_M, 3'd3);
      6'd38: u = mk(OP_NACC,   A_ADJ, 4'd7, B_M, 3'd4);
      6'd39: u = mk(OP_NMAX,   A_M,   4'd0, B_M, 3'd0);
      6'd40: u = mk(OP_NFIRST, A_ADJ, 4'd2, B_M, 3'd2);
      6'd41: u = mk(OP_NACC,   A_ADJ, 4'd5, B_M, 3'd4);
      6'd42: u = mk(OP_NACC,   A_ADJ, 4'd8, B_M, 3'd5);
      6'd43: u = mk(OP_NMAX,   A_M,   4'd0, B_M, 3'd0);
      // condition: |det| * limit >= best * n1
      6'd44: u = mk(OP_MSET,    A_BEST,   4'd0, B_N1,    3'd0);
      6'd45: u = mk(OP_STPROD,  A_M,      4'd0, B_M,     3'd0);
      6'd46: u = mk(OP_MSET,    A_DETMAG, 4'd0, B_LIMIT, 3'd0);
      6'd47: u = mk(OP_CHKCOND, A_M,      4'd0, B_M,     3'd0);
      // numerators and quotients
      6'd48: u = mk(OP_MSET, A_ADJ, 4'd0, B_S, 3'd0);
      6'd49: u = mk(OP_MADD, A_ADJ, 4'd1, B_S, 3'd1);
      6'd50: u = mk(OP_MADD, A_ADJ, 4'd2, B_S, 3'd2);
      6'd51: u = mk(OP_DIV,  A_M,   4'd0, B_M, 3'd0);
      6'd52: u = mk(OP_MSET, A_ADJ, 4'd3, B_S, 3'd0);
      6'd53: u = mk(OP_MADD, A_ADJ, 4'd4, B_S, 3'd1);
      6'd54: u = mk(OP_MADD, A_ADJ, 4'd5, B_S, 3'd2);
      6'd55: u = mk(OP_DIV,  A_M,   4'd1, B_M, 3'd0);
      6'd56: u = mk(OP_MSET, A_ADJ, 4'd6, B_S, 3'd0);
      6'd57: u = mk(OP_MADD, A_ADJ, 4'd7, B_S, 3'd1);
      6'd58: u = mk(OP_MADD, A_ADJ, 4'd8, B_S, 3'd2);
      6'd59: u = mk(OP_DIV,  A_M,   4'd2, B_M, 3'd0);
      default: u = mk(OP_END, A_M, 4'd0, B_M, 3'd0);
    endcase
    return u;
  endfunction

endpackage

[sv/sunls_ctrl.sv]
module sunls_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output sunls_pkg::cmd_t     cmd,
  input  sunls_pkg::stat_t    stat
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ACC   = 6'b000010,
    S_CHECK = 6'b000100,
    S_RUN   = 6'b001000,
    S_WAIT  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                          state, state_next;
  logic [sunls_pkg::PcW-1:0]       pc, pc_next;
  logic [1:0]                      phase, phase_next;
  sunls_pkg::status_code_t         est, est_next;
  sunls_pkg::uop_t                 uop;

  assign uop = sunls_pkg::ucode(pc);

  always_comb begin
    state_next      = state;
    pc_next         = pc;
    phase_next      = phase;
    est_next        = est;
    s_tready        = 1'b0;
    cmd             = '0;
    cmd.acc_phase   = phase;
    cmd.uop         = uop;
    cmd.emit_status = est;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          phase_next = 2'd0;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        phase_next = phase + 2'd1;
        if (phase == 2'd2) begin
          state_next = stat.last ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        if (!stat.enough) begin
          est_next   = sunls_pkg::ST_FEW;
          state_next = S_EMIT;
        end else begin
          pc_next    = '0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.exec = 1'b1;
        case (uop.op)
          sunls_pkg::OP_MSET, sunls_pkg::OP_MSUB, sunls_pkg::OP_MADD,
          sunls_pkg::OP_DIV: begin
            state_next = S_WAIT;
          end
          sunls_pkg::OP_CHKDET: begin
            if (stat.det_zero) begin
              est_next   = sunls_pkg::ST_ILL;
              state_next = S_EMIT;
            end else begin
              pc_next = pc + 1'b1;
            end
          end
          sunls_pkg::OP_CHKCOND: begin
            if (stat.cond_fail) begin
              est_next   = sunls_pkg::ST_ILL;
              state_next = S_EMIT;
            end else begin
              pc_next = pc + 1'b1;
            end
          end
          sunls_pkg::OP_END: begin
            est_next   = sunls_pkg::ST_VALID;
            state_next = S_EMIT;
          end
          default: begin
            pc_next = pc + 1'b1;
          end
        endcase
      end
      S_WAIT: begin
        if (!stat.busy) begin
          pc_next    = pc + 1'b1;
          state_next = S_RUN;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      phase <= '0;
      est   <= sunls_pkg::ST_VALID;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      phase <= phase_next;
      est   <= est_next;
    end
  end

endmodule

[sv/sunls_datapath.sv]
module sunls_datapath #(
  parameter int MAX_SENSORS = 18,
  parameter int CntW        = 5,
  parameter int PSumW       = 34,
  parameter int ISumW       = 36
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sunls_pkg::cmd_t                       cmd,
  output sunls_pkg::stat_t                      stat,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [23:0]                           cfg_data,
  input  logic [15:0]                           intensity,
  input  logic signed [sunls_pkg::NormW-1:0]    normal_x,
  input  logic signed [sunls_pkg::NormW-1:0]    normal_y,
  input  logic signed [sunls_pkg::NormW-1:0]    normal_z,
  input  logic                                  last_sensor,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [sunls_pkg::OutW-1:0]     sun_x,
  output logic signed [sunls_pkg::OutW-1:0]     sun_y,
  output logic signed [sunls_pkg::OutW-1:0]     sun_z,
  output sunls_pkg::status_code_t               status
);

  localparam int WideW = sunls_pkg::WideW;
  localparam int BW    = sunls_pkg::BW;
  localparam int OutW  = sunls_pkg::OutW;
  localparam int NormW = sunls_pkg::NormW;
  localparam int MCntW = $clog2(BW);
  localparam int DCntW = $clog2(WideW);

  function automatic logic signed [NormW-1:0] clamp(logic signed [NormW-1:0] v);
    logic signed [NormW-1:0] r;
    r = v;
    if (v > sunls_pkg::NormMax) r = sunls_pkg::NormMax;
    if (v < sunls_pkg::NormMin) r = sunls_pkg::NormMin;
    return r;
  endfunction

  // configuration
  logic [15:0] thr;
  logic [23:0] lim;

  // latched item
  logic signed [NormW-1:0] nx, ny, nz;
  logic [15:0]             inten;
  logic                    last_q, lit_q;

  // running sums
  logic signed [PSumW-1:0] psum [6];
  logic signed [ISumW-1:0] isum [3];
  logic [CntW-1:0]         cnt;

  // solve state
  logic [WideW-1:0] adj [9];
  logic [WideW-1:0] det, prod, best, acs;
  logic [BW-1:0]    n1, cs;

  // shift-add multiplier; macc doubles as the working accumulator
  logic [WideW-1:0] macc, mc;
  logic [BW-1:0]    mb;
  logic [MCntW-1:0] mcnt;
  logic             mbusy;

  // restoring divider
  logic [WideW-1:0] dvd, dsr, rem, quo;
  logic [DCntW-1:0] dcnt;
  logic [1:0]       didx;
  logic             dneg, dbusy;

  logic signed [OutW-1:0] vec [3];

  // accumulate-phase multipliers
  logic signed [NormW:0]     ma [3];
  logic signed [NormW:0]     mv [3];
  logic signed [2*NormW+1:0] pr [3];

  logic signed [NormW:0] ix;
  assign ix = $signed({1'b0, inten});

  always_comb begin
    case (cmd.acc_phase)
      2'd0: begin
        ma[0] = (NormW+1)'(nx); mv[0] = (NormW+1)'(nx);
        ma[1] = (NormW+1)'(nx); mv[1] = (NormW+1)'(ny);
        ma[2] = (NormW+1)'(nx); mv[2] = (NormW+1)'(nz);
      end
      2'd1: begin
        ma[0] = (NormW+1)'(ny); mv[0] = (NormW+1)'(ny);
        ma[1] = (NormW+1)'(ny); mv[1] = (NormW+1)'(nz);
        ma[2] = (NormW+1)'(nz); mv[2] = (NormW+1)'(nz);
      end
      default: begin
        ma[0] = ix; mv[0] = (NormW+1)'(nx);
        ma[1] = ix; mv[1] = (NormW+1)'(ny);
        ma[2] = ix; mv[2] = (NormW+1)'(nz);
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      pr[k] = ma[k] * mv[k];
    end
  end

  // operand selection
  logic [WideW-1:0] a_op, det_mag;
  logic [BW-1:0]    b_op;

  assign det_mag = det[WideW-1] ? -det : det;

  always_comb begin
    case (cmd.uop.asel)
      sunls_pkg::A_M:      a_op = WideW'(psum[cmd.uop.aidx[2:0]]);
      sunls_pkg::A_ADJ:    a_op = adj[cmd.uop.aidx];
      sunls_pkg::A_BEST:   a_op = best;
      sunls_pkg::A_DETMAG: a_op = det_mag;
      default:             a_op = '0;
    endcase
    case (cmd.uop.bsel)
      sunls_pkg::B_M:     b_op = BW'(psum[cmd.uop.bidx]);
      sunls_pkg::B_S:     b_op = BW'(isum[cmd.uop.bidx[1:0]]);
      sunls_pkg::B_N1:    b_op = n1;
      sunls_pkg::B_LIMIT: b_op = BW'(lim);
      default:            b_op = '0;
    endcase
  end

  logic [WideW-1:0] a_abs;
  logic [BW-1:0]    b_abs;
  assign a_abs = a_op[WideW-1] ? -a_op : a_op;
  assign b_abs = b_op[BW-1] ? -b_op : b_op;

  // divider step
  logic [WideW-1:0] r_sh, q_nx, t_mag;
  logic             r_ge;
  logic [OutW:0]    cap;
  logic [OutW-1:0]  qv;
  assign r_sh  = {rem[WideW-2:0], dvd[WideW-1]};
  assign r_ge  = r_sh >= dsr;
  assign q_nx  = {quo[WideW-2:0], r_ge};
  assign t_mag = macc[WideW-1] ? -macc : macc;
  assign cap   = dneg ? sunls_pkg::CapNeg : sunls_pkg::CapPos;
  assign qv    = (q_nx > WideW'(cap)) ? cap[OutW-1:0] : q_nx[OutW-1:0];

  logic lit_in;
  assign lit_in = (intensity > thr) && (cnt < CntW'(MAX_SENSORS));

  assign stat.busy      = mbusy | dbusy;
  assign stat.last      = last_q;
  assign stat.enough    = cnt >= CntW'(3);
  assign stat.det_zero  = det == '0;
  assign stat.cond_fail = !(macc >= prod);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= 16'd16384;
      lim       <= 24'd1000000;
      cnt       <= '0;
      mbusy     <= 1'b0;
      dbusy     <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < 6; k++) psum[k] <= '0;
      for (int k = 0; k < 3; k++) isum[k] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index) lim <= cfg_data;
        else           thr <= cfg_data[15:0];
      end

      if (cmd.load) begin
        nx     <= clamp(normal_x);
        ny     <= clamp(normal_y);
        nz     <= clamp(normal_z);
        inten  <= intensity;
        last_q <= last_sensor;
        lit_q  <= lit_in;
      end

      if (cmd.acc && lit_q) begin
        case (cmd.acc_phase)
          2'd0: begin
            for (int k = 0; k < 3; k++) psum[k] <= psum[k] + PSumW'(pr[k]);
          end
          2'd1: begin
            for (int k = 0; k < 3; k++) psum[k+3] <= psum[k+3] + PSumW'(pr[k]);
          end
          default: begin
            for (int k = 0; k < 3; k++) isum[k] <= isum[k] + ISumW'(pr[k]);
            cnt <= cnt + 1'b1;
          end
        endcase
      end

      if (out_valid && out_ready && !cmd.emit) out_valid <= 1'b0;

      if (cmd.emit) begin
        out_valid <= 1'b1;
        status    <= cmd.emit_status;
        if (cmd.emit_status == sunls_pkg::ST_VALID) begin
          sun_x <= vec[0];
          sun_y <= vec[1];
          sun_z <= vec[2];
        end else begin
          sun_x <= '0;
          sun_y <= '0;
          sun_z <= '0;
        end
        cnt <= '0;
        for (int k = 0; k < 6; k++) psum[k] <= '0;
        for (int k = 0; k < 3; k++) isum[k] <= '0;
      end

      // multiplier iterations: B is signed, so its top bit weighs negative
      if (mbusy) begin
        if (mb[0]) begin
          macc <= (mcnt == MCntW'(BW - 1)) ? macc - mc : macc + mc;
        end
        mc   <= mc << 1;
        mb   <= mb >> 1;
        mcnt <= mcnt + 1'b1;
        if (mcnt == MCntW'(BW - 1)) mbusy <= 1'b0;
      end

      if (dbusy) begin
        rem  <= r_ge ? r_sh - dsr : r_sh;
        quo  <= q_nx;
        dvd  <= dvd << 1;
        dcnt <= dcnt + 1'b1;
        if (dcnt == DCntW'(WideW - 1)) begin
          dbusy      <= 1'b0;
          vec[didx]  <= dneg ? -qv : qv;
        end
      end

      if (cmd.exec) begin
        case (cmd.uop.op)
          sunls_pkg::OP_MSET, sunls_pkg::OP_MSUB, sunls_pkg::OP_MADD: begin
            if (cmd.uop.op == sunls_pkg::OP_MSET) macc <= '0;
            mc    <= (cmd.uop.op == sunls_pkg::OP_MSUB) ? -a_op : a_op;
            mb    <= b_op;
            mcnt  <= '0;
            mbusy <= 1'b1;
          end
          sunls_pkg::OP_STADJ: adj[cmd.uop.aidx] <= macc;
          sunls_pkg::OP_STDET: begin
            det  <= macc;
            best <= '0;
            n1   <= '0;
          end
          sunls_pkg::OP_NFIRST: begin
            acs <= a_abs;
            cs  <= b_abs;
          end
          sunls_pkg::OP_NACC: begin
            acs <= acs + a_abs;
            cs  <= cs + b_abs;
          end
          sunls_pkg::OP_NMAX: begin
            if (acs > best) best <= acs;
            if (cs > n1)    n1   <= cs;
          end
          sunls_pkg::OP_STPROD: prod <= macc;
          sunls_pkg::OP_DIV: begin
            dvd   <= (t_mag << 16) + det_mag;
            dsr   <= det_mag << 1;
            rem   <= '0;
            quo   <= '0;
            dneg  <= macc[WideW-1] ^ det[WideW-1];
            didx  <= cmd.uop.aidx[1:0];
            dcnt  <= '0;
            dbusy <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[sv/sun_vector_least_squares.sv]
// Coarse sun-sensor least-squares sun vector. One sensor reading per input
// item; a reading brighter than intensity_threshold (and while fewer than
// MAX_SENSORS are in the set) is folded into the Gram sums H^T H and H^T y
// by three shared 17x17 multipliers over three phases, and no new item is
// taken until they are done. The item with tlast closes the set and yields
// one output item: status 1 and a zero vector with fewer than three lit
// sensors, status 2 and a zero vector for a singular matrix or when
// norm1(M)*norm1(inv M) exceeds condition_limit, otherwise inv(M)*H^T y in
// Q3.16, rounded and saturated. The solve is run by a small microprogram
// over one shift-add multiplier (32 products) and a restoring divider (one
// division per component), during which no input is taken. Sums and count
// clear when the result is loaded into the output register. m_tvalid holds
// until m_tready; a new set may start while it waits.
module sun_vector_least_squares #(
  parameter int MAX_SENSORS = 18
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // intensity, normal_x, normal_y, normal_z
  input  logic        s_tlast,   // last_sensor
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // sun_x, sun_y, sun_z, zero pad
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int CntW  = $clog2(MAX_SENSORS + 1);
  localparam int PSumW = $clog2(MAX_SENSORS + 1) + 29;
  localparam int ISumW = $clog2(MAX_SENSORS + 1) + 31;

  sunls_pkg::cmd_t          cmd;
  sunls_pkg::stat_t         stat;
  sunls_pkg::status_code_t  st;
  logic signed [sunls_pkg::OutW-1:0] sx, sy, sz;

  sunls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  sunls_datapath #(
    .MAX_SENSORS (MAX_SENSORS),
    .CntW        (CntW),
    .PSumW       (PSumW),
    .ISumW       (ISumW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .intensity   (s_tdata[15:0]),
    .normal_x    (s_tdata[31:16]),
    .normal_y    (s_tdata[47:32]),
    .normal_z    (s_tdata[63:48]),
    .last_sensor (s_tlast),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .sun_x       (sx),
    .sun_y       (sy),
    .sun_z       (sz),
    .status      (st)
  );

  assign m_tdata = {4'b0000, sz, sy, sx};
  assign m_tuser = st;

endmodule

[tb/sv/tb_sun_vector_least_squares.sv]
`timescale 1ns / 1ps

class sun_scoreboard;
  // expected sun vector and status, oldest first
  logic [19:0] want_x[$];
  logic [19:0] want_y[$];
  logic [19:0] want_z[$];
  logic [1:0]  want_st[$];
  int          errors;

  // estimator state
  logic [15:0]        thresh;
  logic [23:0]        cond_lim;
  logic signed [63:0] gram[6];
  logic signed [63:0] proj[3];
  int                 lit;

  function void clear_sums();
    for (int i = 0; i < 6; i++) gram[i] = 0;
    for (int i = 0; i < 3; i++) proj[i] = 0;
    lit = 0;
  endfunction

  function void reset_state();
    thresh = 16384;
    cond_lim = 1000000;
    clear_sums();
  endfunction

  function logic signed [63:0] clamp_norm(logic [15:0] raw);
    logic signed [63:0] s;
    s = $signed(raw);
    if (s > 16384) s = 16384;
    if (s < -16384) s = -16384;
    return s;
  endfunction

  function logic signed [255:0] mag(logic signed [255:0] v);
    return v < 0 ? -v : v;
  endfunction

  // solve the 3x3 normal equations; fills vector, returns status
  function logic [1:0] solve_set(output logic [19:0] vx, output logic [19:0] vy,
                                 output logic [19:0] vz);
    logic signed [255:0] a[3][3];
    logic signed [255:0] adj[3][3];
    logic signed [255:0] det, best, n1, cs, acs, num, dm, nm, q;
    logic [19:0] res[3];
    logic neg;
    a[0][0] = gram[0]; a[0][1] = gram[1]; a[0][2] = gram[2];
    a[1][0] = gram[1]; a[1][1] = gram[3]; a[1][2] = gram[4];
    a[2][0] = gram[2]; a[2][1] = gram[4]; a[2][2] = gram[5];
    adj[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
    adj[0][1] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
    adj[0][2] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
    adj[1][0] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
    adj[1][1] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
    adj[1][2] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
    adj[2][0] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
    adj[2][1] = a[0][1]*a[2][0] - a[0][0]*a[2][1];
    adj[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
    vx = 0; vy = 0; vz = 0;
    det = a[0][0]*adj[0][0] + a[0][1]*adj[1][0] + a[0][2]*adj[2][0];
    if (det == 0) return sunls_pkg::ST_ILL;
    n1 = 0; best = 0;
    for (int j = 0; j < 3; j++) begin
      cs = 0; acs = 0;
      for (int i = 0; i < 3; i++) begin
        cs += mag(a[i][j]);
        acs += mag(adj[i][j]);
      end
      if (cs > n1) n1 = cs;
      if (acs > best) best = acs;
    end
    dm = mag(det);
    if (best * n1 > dm * $signed({232'd0, cond_lim})) return sunls_pkg::ST_ILL;
    for (int i = 0; i < 3; i++) begin
      num = adj[i][0]*proj[0] + adj[i][1]*proj[1] + adj[i][2]*proj[2];
      neg = (num < 0) != (det < 0);
      nm = mag(num);
      // round to nearest, ties away from zero
      q = ((nm <<< 16) + dm) / (dm <<< 1);
      if (neg) begin
        if (q > 524288) q = 524288;
        q = -q;
      end else if (q > 524287) q = 524287;
      res[i] = q[19:0];
    end
    vx = res[0]; vy = res[1]; vz = res[2];
    return sunls_pkg::ST_VALID;
  endfunction

  function void write_reg(bit idx, logic [23:0] val);
    if (idx == 0) thresh = val[15:0];
    else cond_lim = val;
  endfunction

  // fold one accepted reading in; on the last one queue the expected result
  function void note_reading(logic [63:0] data, logic last);
    logic signed [63:0] n[3];
    logic signed [63:0] inten;
    logic [19:0] vx, vy, vz;
    logic [1:0] st;
    inten = data[15:0];
    if (data[15:0] > thresh && lit < 18) begin
      n[0] = clamp_norm(data[31:16]);
      n[1] = clamp_norm(data[47:32]);
      n[2] = clamp_norm(data[63:48]);
      gram[0] += n[0]*n[0]; gram[1] += n[0]*n[1]; gram[2] += n[0]*n[2];
      gram[3] += n[1]*n[1]; gram[4] += n[1]*n[2]; gram[5] += n[2]*n[2];
      for (int k = 0; k < 3; k++) proj[k] += inten * n[k];
      lit++;
    end
    if (!last) return;
    if (lit < 3) begin
      st = sunls_pkg::ST_FEW; vx = 0; vy = 0; vz = 0;
    end else begin
      st = solve_set(vx, vy, vz);
    end
    want_x.push_back(vx); want_y.push_back(vy); want_z.push_back(vz);
    want_st.push_back(st);
    clear_sums();
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_result(logic [63:0] data, logic [1:0] st);
    if (want_st.size() == 0) begin
      report("unexpected result item");
      return;
    end
    if (data[19:0] !== want_x[0])
      report($sformatf("sun_x got %h want %h", data[19:0], want_x[0]));
    if (data[39:20] !== want_y[0])
      report($sformatf("sun_y got %h want %h", data[39:20], want_y[0]));
    if (data[59:40] !== want_z[0])
      report($sformatf("sun_z got %h want %h", data[59:40], want_z[0]));
    if (data[63:60] !== 4'd0) report("pad bits not zero");
    if (st !== want_st[0]) report($sformatf("status got %0d want %0d", st, want_st[0]));
    void'(want_x.pop_front()); void'(want_y.pop_front());
    void'(want_z.pop_front()); void'(want_st.pop_front());
  endtask
endclass

module tb_sun_vector_least_squares;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = 0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [23:0] cfg_data = 0;

  sun_scoreboard sb;
  bit            sink_on = 0;

  always #4 clk = ~clk;

  sun_vector_least_squares u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // result side: sample at rising edge, change ready at falling edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (!sink_on) m_tready <= 0;
      else begin
        g = gap_len();
        if (g == 0) m_tready <= 1;
        else begin
          m_tready <= 0;
          repeat (g) @(negedge clk);
          m_tready <= 1;
        end
      end
    end
  end

  task automatic cfg_write(bit idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
  endtask

  // one reading; holds valid until taken
  task automatic send_reading(logic [15:0] inten, logic [15:0] nx, logic [15:0] ny,
                              logic [15:0] nz, logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      s_tvalid <= 0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1;
    s_tdata <= {nz, ny, nx, inten};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_reading({nz, ny, nx, inten}, last);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    s_tvalid <= 0;
  endtask

  // wait for all results, then let any solve still running finish
  task automatic drain();
    drop_valid();
    while (sb.want_st.size() != 0) @(posedge clk);
    repeat (2500) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_norm();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom());      // anything, clamps
    if (r == 1) return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  // a set of readings with random content; small sets mostly
  task automatic random_set(int n_read);
    for (int i = 0; i < n_read; i++)
      send_reading($urandom_range(0, 3) == 0 ? 16'($urandom()) :
                   16'($urandom_range(16000, 65535)),
                   rnd_norm(), rnd_norm(), rnd_norm(), i == n_read - 1);
  endtask

  int sent;

  initial begin
    sb = new();
    sb.reset_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    sink_on = 1;

    // directed: orthogonal faces, singular, too few, clamping, extremes
    send_reading(16'hFFFF, 16'sd16384, 0, 0, 0);
    send_reading(16'hFFFF, 0, 16'sd16384, 0, 0);
    send_reading(16'h8000, 0, 0, 16'sd16384, 1);
    send_reading(16'h7000, -16'sd16384, 0, 0, 0);
    send_reading(16'h7000, 0, -16'sd16384, 0, 1);          // too few
    send_reading(16'h4000, 16'sd16384, 0, 0, 0);             // equal to threshold: dark
    send_reading(16'hFFFF, 16'sd16384, 0, 0, 0);
    send_reading(16'hFFFF, 16'sd16384, 0, 0, 0);
    send_reading(16'hFFFF, 16'sd16384, 0, 0, 1);             // singular
    send_reading(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 0); // out of range normals
    send_reading(16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 0);
    send_reading(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 1);
    send_reading(16'hFFFF, 16'sd1, 0, 0, 0);                 // tiny axis: ill-conditioned
    send_reading(16'hFFFF, 0, 16'sd16384, 0, 0);
    send_reading(16'hFFFF, 0, 0, 16'sd16384, 1);
    for (int i = 0; i < 22; i++)                              // more than the sensor cap
      send_reading(16'hFFFF, rnd_norm(), rnd_norm(), rnd_norm(), i == 21);
    drain();

    // register extremes, then random phases
    cfg_write(0, 24'd0);
    cfg_write(1, 24'd1);
    random_set(4);
    random_set(3);
    drain();
    cfg_write(0, 24'hFFFF);
    cfg_write(1, 24'hFFFFFF);
    random_set(5);                                           // all dark
    drain();
    cfg_write(0, 24'd16384);
    cfg_write(1, 24'd64);
    random_set(6);
    random_set(3);
    drain();

    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(0, 24'($urandom_range(0, 40000)));
      cfg_write(1, ph == 0 ? 24'hFFFFFF : 24'($urandom_range(1, 24'hFFFFFF)));
      while (sent < (ph + 1) * 250) begin
        int n;
        n = $urandom_range(0, 19) == 0 ? $urandom_range(15, 22) : $urandom_range(1, 6);
        random_set(n);
        sent += n;
      end
      drain();
    end

    if (sb.errors == 0 && sb.want_st.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

[filelist.f]
sv/sunls_pkg.sv
sv/sunls_ctrl.sv
sv/sunls_datapath.sv
sv/sun_vector_least_squares.sv
tb/sv/tb_sun_vector_least_squares.sv
